// ===== hw/rtl/pocc_pkg.sv =====
// ----------------------------------------------------------------------------
// pocc_pkg
// Shared types, codes and helpers for the picture order count calculator.
// ----------------------------------------------------------------------------
package pocc_pkg;

   // Request operations carried on tuser.
   localparam logic OP_SLICE = 1'b0;
   localparam logic OP_TABLE = 1'b1;

   // Picture order count types.
   localparam logic [1:0] TYPE_LSB    = 2'd0;
   localparam logic [1:0] TYPE_CYCLE  = 2'd1;
   localparam logic [1:0] TYPE_FRAME  = 2'd2;
   localparam logic [1:0] TYPE_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_COUNT_TYPE    = 3'd0;
   localparam logic [2:0] REG_LOG2_LSB      = 3'd1;
   localparam logic [2:0] REG_LOG2_FRAME    = 3'd2;
   localparam logic [2:0] REG_NON_REF       = 3'd3;
   localparam logic [2:0] REG_TOP_TO_BOTTOM = 3'd4;
   localparam logic [2:0] REG_CYCLE_LENGTH  = 3'd5;

   localparam logic [4:0] LOG2_MIN = 5'd4;
   localparam logic [4:0] LOG2_MAX = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_BASE,
      ST_CHECK,
      ST_DIV,
      ST_WALK,
      ST_DRAIN,
      ST_MUL,
      ST_SUM,
      ST_TOP,
      ST_BOTTOM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic base;
      logic div_init;
      logic div_step;
      logic walk_init;
      logic walk_issue;
      logic mul;
      logic sum;
      logic top;
      logic bottom;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] count_type;
      logic       absn_nz;
      logic       div_last;
      logic       walk_last;
      logic       out_free;
   } status_type;

   // Log2 registers outside 4..16 behave as the nearest bound.
   function automatic logic [4:0] clamp_log2(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      if (v < LOG2_MIN) r = LOG2_MIN;
      if (v > LOG2_MAX) r = LOG2_MAX;
      return r;
   endfunction

   // Mask of the low lg bits, lg already clamped to 4..16.
   function automatic logic [15:0] low_mask(input logic [4:0] lg);
      logic [16:0] m;
      m = (17'd1 << lg) - 17'd1;
      return m[15:0];
   endfunction

endpackage

// ===== hw/rtl/pocc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pocc_ctrl
// Sequencer that steps the datapath through one slice derivation.
// ----------------------------------------------------------------------------
module pocc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   input  pocc_pkg::status_type status,
   output pocc_pkg::cmd_type    cmd,
   output logic                req_ready
);
   import pocc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op == OP_SLICE && status.count_type != TYPE_UNUSED) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:  state_in = ST_BASE;
         ST_BASE:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.count_type == TYPE_CYCLE && status.absn_nz) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_TOP;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_MUL;
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_TOP;
         ST_TOP:    state_in = ST_BOTTOM;
         ST_BOTTOM: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PREP:  cmd.prep = 1'b1;
         ST_BASE:  cmd.base = 1'b1;
         ST_CHECK: cmd.div_init = (status.count_type == TYPE_CYCLE) && status.absn_nz;
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.walk_init = status.div_last;
         end
         ST_WALK:   cmd.walk_issue = 1'b1;
         ST_DRAIN:  cmd = '0;
         ST_MUL:    cmd.mul = 1'b1;
         ST_SUM:    cmd.sum = 1'b1;
         ST_TOP:    cmd.top = 1'b1;
         ST_BOTTOM: cmd.bottom = 1'b1;
         ST_EMIT:   cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/pocc_datapath.sv =====
// ----------------------------------------------------------------------------
// pocc_datapath
// Configuration, history, cycle offset table, divider, table walk and
// result register of the picture order count calculator.
// ----------------------------------------------------------------------------
module pocc_datapath #(
   parameter int CYCLE_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pocc_pkg::cmd_type     cmd,
   output pocc_pkg::status_type  status,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 in_op,
   input  logic                 in_idr,
   input  logic                 in_ref,
   input  logic [15:0]          in_frame_number,
   input  logic [15:0]          in_count_lsb,
   input  logic [31:0]          in_delta_top,
   input  logic [31:0]          in_delta_bottom,
   input  logic [7:0]           in_table_index,
   input  logic [31:0]          in_table_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_top,
   output logic [31:0]          rsp_bottom
);
   import pocc_pkg::*;

   localparam int AddrWidth = (CYCLE_TABLE_DEPTH > 1) ? $clog2(CYCLE_TABLE_DEPTH) : 1;
   localparam logic [8:0] DepthLimit = 9'(CYCLE_TABLE_DEPTH);

   // Configuration registers.
   logic [1:0]  count_type_ff;
   logic [4:0]  log2_lsb_ff;
   logic [4:0]  log2_frame_ff;
   logic [31:0] non_ref_ff;
   logic [31:0] top_to_bottom_ff;
   logic [7:0]  cycle_length_ff;

   // History.
   logic [15:0] prev_lsb_ff, prev_lsb_in;
   logic [31:0] prev_msb_ff, prev_msb_in;
   logic [31:0] prev_off_ff, prev_off_in;
   logic [15:0] prev_fnum_ff, prev_fnum_in;

   // Captured slice.
   logic        idr_ff, idr_in;
   logic        ref_ff, ref_in;
   logic [15:0] fnum_ff, fnum_in;
   logic [15:0] lsb_ff, lsb_in;
   logic [31:0] dtop_ff, dtop_in;
   logic [31:0] dbot_ff, dbot_in;

   // Working registers.
   logic [31:0] base_ff, base_in;
   logic [31:0] absn_ff, absn_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [7:0]  walk_idx_ff, walk_idx_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_idx_ff, pend_idx_in;
   logic [31:0] per_ff, per_in;
   logic [31:0] part_ff, part_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] top_ff, top_in;
   logic [31:0] bot_ff, bot_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_top_ff, out_top_in;
   logic [31:0] out_bot_ff, out_bot_in;

   // Cycle offset table.
   logic [31:0] table_mem [CYCLE_TABLE_DEPTH];
   logic [31:0] rd_data_ff;

   logic [4:0]  lg_lsb;
   logic [4:0]  lg_frame;
   logic [31:0] max_lsb;
   logic [31:0] half_lsb;
   logic [31:0] max_frame;
   logic [15:0] plsb;
   logic [31:0] pmsb;
   logic [31:0] poff;
   logic [31:0] msb;
   logic [31:0] offset;
   logic [31:0] frame_sum;
   logic [8:0]  div_trial;
   logic        div_ge;
   logic [31:0] walk_val;
   logic        wr_in_range;
   logic        rd_in_range;
   logic        accept;

   assign accept      = cmd.capture;
   assign lg_lsb      = clamp_log2(log2_lsb_ff);
   assign lg_frame    = clamp_log2(log2_frame_ff);
   assign max_lsb     = 32'd1 << lg_lsb;
   assign half_lsb    = max_lsb >> 1;
   assign max_frame   = 32'd1 << lg_frame;
   assign wr_in_range = {1'b0, in_table_index} < DepthLimit;
   assign rd_in_range = {1'b0, walk_idx_ff} < DepthLimit;

   // An IDR slice sees cleared history.
   assign plsb = idr_ff ? 16'd0 : prev_lsb_ff;
   assign pmsb = idr_ff ? 32'd0 : prev_msb_ff;
   assign poff = idr_ff ? 32'd0 : prev_off_ff;

   always_comb begin
      if (32'(lsb_ff) < 32'(plsb) && (32'(plsb) - 32'(lsb_ff)) >= half_lsb) begin
         msb = pmsb + max_lsb;
      end else if (32'(lsb_ff) > 32'(plsb) && (32'(lsb_ff) - 32'(plsb)) > half_lsb) begin
         msb = pmsb - max_lsb;
      end else begin
         msb = pmsb;
      end
   end

   always_comb begin
      if (idr_ff) begin
         offset = 32'd0;
      end else if (prev_fnum_ff > fnum_ff) begin
         offset = prev_off_ff + max_frame;
      end else begin
         offset = prev_off_ff;
      end
   end

   assign frame_sum = base_ff + 32'(fnum_ff);
   assign div_trial = {rem_ff, quo_ff[31]};
   assign div_ge    = div_trial >= {1'b0, cycle_length_ff};
   assign walk_val  = ({1'b0, pend_idx_ff} < DepthLimit) ? rd_data_ff : 32'd0;

   always_comb begin
      prev_lsb_in   = prev_lsb_ff;
      prev_msb_in   = prev_msb_ff;
      prev_off_in   = prev_off_ff;
      prev_fnum_in  = prev_fnum_ff;
      idr_in        = idr_ff;
      ref_in        = ref_ff;
      fnum_in       = fnum_ff;
      lsb_in        = lsb_ff;
      dtop_in       = dtop_ff;
      dbot_in       = dbot_ff;
      base_in       = base_ff;
      absn_in       = absn_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      walk_idx_in   = walk_idx_ff;
      pend_valid_in = cmd.walk_issue;
      pend_idx_in   = walk_idx_ff;
      per_in        = per_ff;
      part_in       = part_ff;
      prod_in       = prod_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      out_top_in    = out_top_ff;
      out_bot_in    = out_bot_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (accept) begin
         idr_in  = in_idr;
         ref_in  = in_ref;
         fnum_in = in_frame_number & low_mask(lg_frame);
         lsb_in  = in_count_lsb & low_mask(lg_lsb);
         dtop_in = in_delta_top;
         dbot_in = in_delta_bottom;
      end

      if (cmd.prep) begin
         prev_fnum_in = fnum_ff;
         if (count_type_ff == TYPE_LSB) begin
            base_in     = msb;
            prev_off_in = poff;
            prev_lsb_in = ref_ff ? lsb_ff : plsb;
            prev_msb_in = ref_ff ? msb : pmsb;
         end else begin
            base_in     = offset;
            prev_off_in = offset;
            prev_lsb_in = plsb;
            prev_msb_in = pmsb;
         end
      end

      if (cmd.base) begin
         acc_in = 32'd0;
         if (cycle_length_ff == 8'd0) begin
            absn_in = 32'd0;
         end else if (!ref_ff && frame_sum != 32'd0) begin
            absn_in = frame_sum - 32'd1;
         end else begin
            absn_in = frame_sum;
         end
         if (count_type_ff == TYPE_FRAME && !idr_ff) begin
            acc_in = {frame_sum[30:0], 1'b0} - {31'd0, !ref_ff};
         end
      end

      if (cmd.div_init) begin
         quo_in     = absn_ff - 32'd1;
         rem_in     = 8'd0;
         div_cnt_in = 5'd0;
      end

      if (cmd.div_step) begin
         rem_in     = div_ge ? 8'(div_trial - {1'b0, cycle_length_ff}) : div_trial[7:0];
         quo_in     = {quo_ff[30:0], div_ge};
         div_cnt_in = div_cnt_ff + 5'd1;
      end

      if (cmd.walk_init) begin
         walk_idx_in = 8'd0;
         per_in      = 32'd0;
         part_in     = 32'd0;
      end

      if (cmd.walk_issue) begin
         walk_idx_in = walk_idx_ff + 8'd1;
      end

      // Entries up to the remainder also count toward the partial cycle.
      if (pend_valid_ff) begin
         per_in = per_ff + walk_val;
         if (pend_idx_ff <= rem_ff) begin
            part_in = part_ff + walk_val;
         end
      end

      if (cmd.mul) begin
         prod_in = quo_ff * per_ff;
      end

      if (cmd.sum) begin
         acc_in = prod_ff + part_ff;
      end

      if (cmd.top) begin
         unique case (count_type_ff)
            TYPE_LSB:   top_in = base_ff + 32'(lsb_ff);
            TYPE_CYCLE: top_in = acc_ff + (ref_ff ? 32'd0 : non_ref_ff) + dtop_ff;
            default:    top_in = acc_ff;
         endcase
      end

      if (cmd.bottom) begin
         unique case (count_type_ff)
            TYPE_LSB:   bot_in = top_ff + dbot_ff;
            TYPE_CYCLE: bot_in = top_ff + top_to_bottom_ff + dbot_ff;
            default:    bot_in = top_ff;
         endcase
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_top_in   = top_ff;
         out_bot_in   = bot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_type_ff    <= TYPE_LSB;
         log2_lsb_ff      <= LOG2_MIN;
         log2_frame_ff    <= LOG2_MIN;
         non_ref_ff       <= 32'd0;
         top_to_bottom_ff <= 32'd0;
         cycle_length_ff  <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COUNT_TYPE:    count_type_ff    <= csr_wdata[1:0];
            REG_LOG2_LSB:      log2_lsb_ff      <= csr_wdata[4:0];
            REG_LOG2_FRAME:    log2_frame_ff    <= csr_wdata[4:0];
            REG_NON_REF:       non_ref_ff       <= csr_wdata;
            REG_TOP_TO_BOTTOM: top_to_bottom_ff <= csr_wdata;
            REG_CYCLE_LENGTH:  cycle_length_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lsb_ff   <= 16'd0;
         prev_msb_ff   <= 32'd0;
         prev_off_ff   <= 32'd0;
         prev_fnum_ff  <= 16'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prev_lsb_ff   <= prev_lsb_in;
         prev_msb_ff   <= prev_msb_in;
         prev_off_ff   <= prev_off_in;
         prev_fnum_ff  <= prev_fnum_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idr_ff      <= idr_in;
      ref_ff      <= ref_in;
      fnum_ff     <= fnum_in;
      lsb_ff      <= lsb_in;
      dtop_ff     <= dtop_in;
      dbot_ff     <= dbot_in;
      base_ff     <= base_in;
      absn_ff     <= absn_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      walk_idx_ff <= walk_idx_in;
      pend_idx_ff <= pend_idx_in;
      per_ff      <= per_in;
      part_ff     <= part_in;
      prod_ff     <= prod_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      out_top_ff  <= out_top_in;
      out_bot_ff  <= out_bot_in;
   end

   always_ff @(posedge clock) begin
      if (accept && in_op == OP_TABLE && wr_in_range) begin
         table_mem[in_table_index[AddrWidth-1:0]] <= in_table_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_issue && rd_in_range) begin
         rd_data_ff <= table_mem[walk_idx_ff[AddrWidth-1:0]];
      end
   end

   assign status.count_type = count_type_ff;
   assign status.absn_nz    = absn_ff != 32'd0;
   assign status.div_last   = div_cnt_ff == 5'd31;
   assign status.walk_last  = walk_idx_ff == (cycle_length_ff - 8'd1);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid  = out_valid_ff;
   assign rsp_top    = out_top_ff;
   assign rsp_bottom = out_bot_ff;

endmodule

// ===== hw/rtl/picture_order_count_calculator.sv =====
// ----------------------------------------------------------------------------
// picture_order_count_calculator
// Derives top and bottom field picture order counts of H.264 slices for
// count types 0, 1 and 2, and maintains the cycle offset table.
// ----------------------------------------------------------------------------
// A table write is taken in the idle state. A type 0 or 2 slice steps through
// the prep, base, check, top, bottom and emit states; a type 1 slice with a
// nonzero absolute frame number also runs the 32-step serial divider and the
// one-entry-a-cycle walk over the table's single read port. One request is in
// work at a time; the next is taken the cycle after the result is registered.
// Reset (synchronous) restores the registers and clears the count history.
module picture_order_count_calculator #(
   parameter int CYCLE_TABLE_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // is_idr, is_ref, frame_number, count_lsb, delta_top, delta_bottom,
   // table_index, table_value, zero pad
   input  logic [143:0]  req_tdata,
   // op
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // top_count, bottom_count
   output logic [63:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   import pocc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [31:0] top_count;
   logic [31:0] bottom_count;

   pocc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_tready)
   );

   pocc_datapath #(
      .CYCLE_TABLE_DEPTH (CYCLE_TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_op           (req_tuser),
      .in_idr          (req_tdata[0]),
      .in_ref          (req_tdata[1]),
      .in_frame_number (req_tdata[17:2]),
      .in_count_lsb    (req_tdata[33:18]),
      .in_delta_top    (req_tdata[65:34]),
      .in_delta_bottom (req_tdata[97:66]),
      .in_table_index  (req_tdata[105:98]),
      .in_table_value  (req_tdata[137:106]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_top         (top_count),
      .rsp_bottom      (bottom_count)
   );

   assign rsp_tdata = {bottom_count, top_count};

endmodule

// ===== bench/poc_checker.sv =====
// ----------------------------------------------------------------------------
// poc_checker
// Watches the request, result and register ports of the picture order count
// calculator. It keeps its own copy of the registers, the count history and
// the cycle offset table, works out the counts of every accepted slice, and
// compares each result with the oldest count pair still outstanding.
// ----------------------------------------------------------------------------
module poc_checker
   import pocc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [143:0]  req_tdata,
   input  logic          req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [63:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   output int            fail_count,
   output int            pending
);

   typedef struct {
      logic [31:0] top;
      logic [31:0] bottom;
   } field_counts_type;

   field_counts_type expected_counts[$];

   logic [1:0]  cfg_type;
   logic [4:0]  cfg_log2_lsb;
   logic [4:0]  cfg_log2_frame;
   logic [31:0] cfg_non_ref;
   logic [31:0] cfg_top_to_bottom;
   logic [7:0]  cfg_cycle_length;

   logic [31:0] hist_lsb;
   logic [31:0] hist_msb;
   logic [31:0] hist_frame_offset;
   logic [31:0] hist_frame_number;
   logic [31:0] offset_table [256];

   function automatic logic [31:0] modulus(input logic [4:0] lg);
      logic [4:0] bounded;
      bounded = (lg < LOG2_MIN) ? LOG2_MIN : ((lg > LOG2_MAX) ? LOG2_MAX : lg);
      return 32'd1 << bounded;
   endfunction

   // Sum of the first count entries of the offset table.
   function automatic logic [31:0] table_sum(input logic [31:0] count);
      logic [31:0] s;
      s = '0;
      for (int i = 0; i < count; i++) s += offset_table[i];
      return s;
   endfunction

   always @(posedge clock) begin : monitor
      logic             idr, is_ref, bad;
      logic [31:0]      max_frame, fnum, max_lsb, half, lsb, msb;
      logic [31:0]      offset, abs_num, sum, top, dtop, dbot;
      field_counts_type got, want;
      if (reset) begin
         cfg_type          = TYPE_LSB;
         cfg_log2_lsb      = LOG2_MIN;
         cfg_log2_frame    = LOG2_MIN;
         cfg_non_ref       = '0;
         cfg_top_to_bottom = '0;
         cfg_cycle_length  = '0;
         hist_lsb          = '0;
         hist_msb          = '0;
         hist_frame_offset = '0;
         hist_frame_number = '0;
         fail_count        = 0;
         expected_counts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_COUNT_TYPE:    cfg_type = csr_wdata[1:0];
               REG_LOG2_LSB:      cfg_log2_lsb = csr_wdata[4:0];
               REG_LOG2_FRAME:    cfg_log2_frame = csr_wdata[4:0];
               REG_NON_REF:       cfg_non_ref = csr_wdata;
               REG_TOP_TO_BOTTOM: cfg_top_to_bottom = csr_wdata;
               REG_CYCLE_LENGTH:  cfg_cycle_length = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.top    = rsp_tdata[31:0];
            got.bottom = rsp_tdata[63:32];
            if (expected_counts.size() == 0) begin
               $display("%0t: result with no slice outstanding: top %h bottom %h",
                        $time, got.top, got.bottom);
               fail_count++;
            end else begin
               want = expected_counts.pop_front();
               bad  = 1'b0;
               if (got.top !== want.top) begin
                  $display("%0t: top_count expected %h, got %h", $time, want.top, got.top);
                  bad = 1'b1;
               end
               if (got.bottom !== want.bottom) begin
                  $display("%0t: bottom_count expected %h, got %h",
                           $time, want.bottom, got.bottom);
                  bad = 1'b1;
               end
               if (bad) fail_count++;
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TABLE) begin
               offset_table[req_tdata[105:98]] = req_tdata[137:106];
            end else if (cfg_type <= TYPE_FRAME) begin
               idr       = req_tdata[0];
               is_ref    = req_tdata[1];
               dtop      = req_tdata[65:34];
               dbot      = req_tdata[97:66];
               max_frame = modulus(cfg_log2_frame);
               fnum      = {16'd0, req_tdata[17:2]} & (max_frame - 32'd1);
               if (idr) begin
                  hist_lsb          = '0;
                  hist_msb          = '0;
                  hist_frame_offset = '0;
                  hist_frame_number = '0;
               end
               if (cfg_type == TYPE_LSB) begin
                  max_lsb = modulus(cfg_log2_lsb);
                  half    = max_lsb >> 1;
                  lsb     = {16'd0, req_tdata[33:18]} & (max_lsb - 32'd1);
                  if (lsb < hist_lsb && hist_lsb - lsb >= half) msb = hist_msb + max_lsb;
                  else if (lsb > hist_lsb && lsb - hist_lsb > half) msb = hist_msb - max_lsb;
                  else msb = hist_msb;
                  top = msb + lsb;
                  want.top    = top;
                  want.bottom = top + dbot;
                  // Only reference pictures move the LSB/MSB history.
                  if (is_ref) begin
                     hist_lsb = lsb;
                     hist_msb = msb;
                  end
               end else begin
                  if (idr) offset = '0;
                  else if (hist_frame_number > fnum) offset = hist_frame_offset + max_frame;
                  else offset = hist_frame_offset;
                  if (cfg_type == TYPE_CYCLE) begin
                     abs_num = (cfg_cycle_length != 0) ? offset + fnum : 32'd0;
                     if (!is_ref && abs_num != 0) abs_num = abs_num - 32'd1;
                     sum = '0;
                     if (abs_num != 0) begin
                        sum = ((abs_num - 32'd1) / 32'(cfg_cycle_length))
                                 * table_sum(32'(cfg_cycle_length))
                            + table_sum((abs_num - 32'd1) % 32'(cfg_cycle_length) + 32'd1);
                     end
                     if (!is_ref) sum = sum + cfg_non_ref;
                     top = sum + dtop;
                     want.top    = top;
                     want.bottom = top + cfg_top_to_bottom + dbot;
                  end else begin
                     if (idr) top = '0;
                     else if (!is_ref) top = 32'd2 * (offset + fnum) - 32'd1;
                     else top = 32'd2 * (offset + fnum);
                     want.top    = top;
                     want.bottom = top;
                  end
                  hist_frame_offset = offset;
               end
               hist_frame_number = fnum;
               expected_counts.insert(expected_counts.size(), want);
            end
         end
      end
      pending = expected_counts.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the picture order count calculator with directed slices covering
// count LSB and frame number wraps, field and register extremes and the
// unused count type, then with random phases of well-formed slice runs mixed
// with noise and table writes. Both stream sides idle at random; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import pocc_pkg::*;

   localparam logic [2:0] REG_SPARE_LOW = 3'd6;
   localparam logic [2:0] REG_SPARE_TOP = 3'd7;
   localparam int SETTLE_CYCLES  = 400;
   localparam int HOLDOFF_CYCLES = 1200;
   localparam int QUIET_LIMIT    = 20000;
   localparam int ITEM_TARGET    = 1200;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;
   logic          csr_we;
   logic [2:0]    csr_index;
   logic [31:0]   csr_wdata;
   int            fail_count;
   int            pending;
   int            holdoff_asks;
   int            quiet_cycles;
   bit            steady;

   picture_order_count_calculator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   poc_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stretches of steady, random and stalled readiness, plus a
   // long hold-off whenever the stimulus asks for one.
   initial begin : receiver
      int holdoff_done;
      int mode;
      int run;
      holdoff_done = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (holdoff_asks != holdoff_done) begin
            holdoff_done++;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 9);
            run  = $urandom_range(10, 120);
            for (int k = 0; k < run; k++) begin
               if (mode < 4) rsp_tready <= 1'b1;
               else if (mode < 8) rsp_tready <= ($urandom_range(0, 99) < 70);
               else if (mode == 8) rsp_tready <= 1'($urandom_range(0, 1));
               else rsp_tready <= (k >= run - 2);
               @(negedge clock);
            end
         end
      end
   end

   function automatic logic [31:0] modulus(input logic [4:0] lg);
      logic [4:0] bounded;
      bounded = (lg < LOG2_MIN) ? LOG2_MIN : ((lg > LOG2_MAX) ? LOG2_MAX : lg);
      return 32'd1 << bounded;
   endfunction

   function automatic logic [31:0] random_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 32'd0;
      if (r < 80) return $urandom_range(0, 64) - 32;
      return $urandom;
   endfunction

   // Offers one request; returns at the falling edge after it was accepted.
   task automatic send_item(input logic op, input logic [143:0] data);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (steady || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic slice(input logic idr, input logic is_ref, input logic [15:0] fnum,
                        input logic [15:0] lsb, input logic [31:0] dtop,
                        input logic [31:0] dbot);
      send_item(OP_SLICE, {6'd0, 32'($urandom), 8'($urandom), dbot, dtop, lsb, fnum,
                           is_ref, idr});
   endtask

   task automatic table_write(input logic [7:0] idx, input logic [31:0] value);
      send_item(OP_TABLE, {6'd0, value, idx, 32'($urandom), 32'($urandom),
                           16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)});
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every slice has its result and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Unused upper bits of the narrow registers carry random junk.
   task automatic configure(input logic [1:0] ctype, input logic [4:0] l2_lsb,
                            input logic [4:0] l2_frame, input logic [31:0] non_ref,
                            input logic [31:0] top_to_bottom, input logic [7:0] cycle_len);
      settle();
      write_reg(REG_COUNT_TYPE, (32'($urandom) & ~32'h3) | 32'(ctype));
      write_reg(REG_LOG2_LSB, (32'($urandom) & ~32'h1f) | 32'(l2_lsb));
      write_reg(REG_LOG2_FRAME, (32'($urandom) & ~32'h1f) | 32'(l2_frame));
      write_reg(REG_NON_REF, non_ref);
      write_reg(REG_TOP_TO_BOTTOM, top_to_bottom);
      write_reg(REG_CYCLE_LENGTH, (32'($urandom) & ~32'hff) | 32'(cycle_len));
   endtask

   initial begin : stimulus
      int          items, phase, n, r;
      logic [1:0]  ctype;
      logic [4:0]  l2_lsb, l2_frame;
      logic [31:0] non_ref, top_to_bottom;
      logic [7:0]  cycle_len;
      logic [31:0] lsb_mod, frame_mod;
      logic [15:0] fnum, lsb;
      logic        idr, is_ref;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = OP_SLICE;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_index    = REG_COUNT_TYPE;
      csr_wdata    = '0;
      holdoff_asks = 0;
      steady       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole offset table so that no type 1 slice reads a stale entry.
      for (int i = 0; i < 256; i++) table_write(i[7:0], $urandom);

      // Count LSB wraps in both directions, the half-range boundary, and a
      // non-reference slice that must leave the history alone.
      configure(TYPE_LSB, 5'd4, 5'd4, 32'd0, 32'd0, 8'd0);
      slice(1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'd1, 16'd15, 32'd0, 32'h7fff_ffff);
      slice(1'b0, 1'b0, 16'd2, 16'd6, 32'd0, 32'h8000_0000);
      slice(1'b0, 1'b1, 16'd2, 16'hfff2, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'd3, 16'd10, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'd4, 16'd2, 32'd0, 32'd0);

      // Log2 registers beyond their bounds.
      configure(TYPE_LSB, 5'd31, 5'd0, 32'd0, 32'd0, 8'd0);
      slice(1'b1, 1'b1, 16'hffff, 16'hffff, 32'h8000_0000, 32'h7fff_ffff);
      slice(1'b0, 1'b1, 16'd0, 16'd0, 32'd0, 32'hffff_ffff);

      // Type 2 with a full-width frame number and its wrap.
      configure(TYPE_FRAME, 5'd3, 5'd16, 32'd0, 32'd0, 8'd0);
      slice(1'b1, 1'b0, 16'hffff, 16'd0, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'hfffe, 16'hffff, 32'd0, 32'd0);
      slice(1'b0, 1'b0, 16'hffff, 16'd0, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0);

      // Type 1 with an empty cycle, then with the longest cycle.
      configure(TYPE_CYCLE, 5'd4, 5'd4, 32'h8000_0000, 32'h7fff_ffff, 8'd0);
      slice(1'b1, 1'b0, 16'd3, 16'd0, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'd5, 16'd0, 32'h7fff_ffff, 32'h8000_0000);
      configure(TYPE_CYCLE, 5'd16, 5'd17, 32'h7fff_ffff, 32'h8000_0000, 8'd255);
      slice(1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0);
      slice(1'b0, 1'b1, 16'h1234, 16'd0, 32'd1, 32'hffff_ffff);
      slice(1'b0, 1'b0, 16'h0010, 16'd0, 32'd0, 32'd0);

      // The unused count type gives nothing and must not touch the history,
      // even for an IDR slice; table writes still land.
      configure(TYPE_UNUSED, 5'd4, 5'd4, 32'd0, 32'd0, 8'd1);
      slice(1'b1, 1'b1, 16'd5, 16'd5, 32'd0, 32'd0);
      slice(1'b0, 1'b0, 16'd9, 16'd9, 32'd0, 32'd0);
      table_write(8'd0, $urandom);
      settle();
      write_reg(REG_SPARE_LOW, $urandom);
      write_reg(REG_SPARE_TOP, $urandom);
      configure(TYPE_FRAME, 5'd4, 5'd4, 32'd0, 32'd0, 8'd1);
      slice(1'b0, 1'b1, 16'd7, 16'd3, 32'd0, 32'd0);

      items = 0;
      phase = 0;
      while (items < ITEM_TARGET) begin
         r = $urandom_range(0, 19);
         ctype = (r < 7) ? TYPE_LSB : (r < 13) ? TYPE_CYCLE : (r < 19) ? TYPE_FRAME
                                                                       : TYPE_UNUSED;
         if (phase == 0) ctype = TYPE_LSB;
         r = $urandom_range(0, 99);
         l2_lsb = (r < 15) ? 5'd4 : (r < 30) ? 5'd16 : (r < 85) ? 5'($urandom_range(4, 16))
                                                                : 5'($urandom);
         r = $urandom_range(0, 99);
         l2_frame = (r < 15) ? 5'd4 : (r < 30) ? 5'd16 : (r < 85) ? 5'($urandom_range(4, 16))
                                                                  : 5'($urandom);
         r = $urandom_range(0, 99);
         non_ref = (r < 10) ? 32'h8000_0000 : (r < 20) ? 32'h7fff_ffff : 32'($urandom);
         r = $urandom_range(0, 99);
         top_to_bottom = (r < 10) ? 32'h8000_0000 : (r < 20) ? 32'h7fff_ffff : 32'($urandom);
         r = $urandom_range(0, 99);
         cycle_len = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : (r < 30) ? 8'($urandom)
                                                                    : 8'($urandom_range(1, 8));
         configure(ctype, l2_lsb, l2_frame, non_ref, top_to_bottom, cycle_len);
         // Early on, hold the result side off while requests keep coming.
         if (phase == 0 || phase == 5) holdoff_asks <= holdoff_asks + 1;
         steady = ($urandom_range(0, 3) == 0);
         lsb_mod   = modulus(l2_lsb);
         frame_mod = modulus(l2_frame);
         if (ctype == TYPE_UNUSED) n = $urandom_range(3, 6);
         else if (ctype == TYPE_CYCLE && cycle_len > 32) n = $urandom_range(4, 12);
         else n = $urandom_range(30, 80);
         fnum = '0;
         lsb  = '0;
         for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               table_write(8'($urandom), $urandom);
            end else if (r < 14) begin
               slice(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                     $urandom, $urandom);
            end else begin
               idr    = (k == 0) || (r < 17);
               is_ref = ($urandom_range(0, 3) != 0);
               if (idr) begin
                  fnum = 16'($urandom) & 16'(frame_mod - 1);
                  lsb  = 16'($urandom) & 16'(lsb_mod - 1);
               end else begin
                  if (r < 22) fnum = 16'($urandom);
                  else fnum = fnum + 16'($urandom_range(0, 2));
                  if ($urandom_range(0, 4) != 0)
                     lsb = lsb + 16'($urandom_range(1, lsb_mod / 2 + 2));
                  else
                     lsb = lsb - 16'($urandom_range(1, lsb_mod / 2 + 2));
                  fnum = fnum & 16'(frame_mod - 1);
                  lsb  = lsb & 16'(lsb_mod - 1);
               end
               // Bits above the active width must be ignored by the block.
               if ($urandom_range(0, 3) == 0) begin
                  slice(idr, is_ref, fnum | (16'($urandom) & ~16'(frame_mod - 1)),
                        lsb | (16'($urandom) & ~16'(lsb_mod - 1)),
                        random_delta(), random_delta());
               end else begin
                  slice(idr, is_ref, fnum, lsb, random_delta(), random_delta());
               end
            end
            if (ctype != TYPE_UNUSED) items++;
         end
         phase++;
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pocc_pkg.sv
hw/rtl/pocc_ctrl.sv
hw/rtl/pocc_datapath.sv
hw/rtl/picture_order_count_calculator.sv
bench/poc_checker.sv
bench/testbench.sv
